// ----- sv/pakl_pkg.sv -----
// ----------------------------------------------------------------------------
// pakl_pkg
// Shared types and constants for the packed automaton key lookup.
// ----------------------------------------------------------------------------
package pakl_pkg;

  localparam int ADDR_W   = 16;
  localparam int SYM_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CELL  = 2'd1;

  localparam logic FUNC_WRITE = 1'b0;

  typedef struct packed {
    logic               table_ready;
    logic [ADDR_W-1:0]  start_cell;
  } cfg_t;

  typedef struct packed {
    logic               is_write;
    logic [ADDR_W-1:0]  cell_addr;
    logic [SYM_W-1:0]   cell_symbol;
    logic [VALUE_W-1:0] cell_value;
    logic [SYM_W-1:0]   key_byte;
    logic               key_last;
    logic               wr_in_table;
    logic               byte_zero;
    logic               byte_final;
  } entry_t;

endpackage

// ----- sv/pakl_front.sv -----
// ----------------------------------------------------------------------------
// pakl_front
// Input stage: accepts beats, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module pakl_front #(
  parameter int TABLE_CELLS = 65536,
  parameter int FINAL_MARK  = 255
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [15:0]             in_cell_addr,
  input  logic [7:0]              in_cell_symbol,
  input  logic [31:0]             in_cell_value,
  input  logic [7:0]              in_key_byte,
  input  logic                    in_key_last,
  output logic                    push,
  output pakl_pkg::entry_t        push_entry,
  input  logic                    q_ready
);
  import pakl_pkg::*;

  localparam logic [24:0] TC = 25'(TABLE_CELLS);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic   in_fire;

  assign in_ready = !valid_r || q_ready;
  assign in_fire  = in_valid && in_ready;
  assign push     = valid_r && q_ready;
  assign push_entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
    entry_nxt.is_write    = (in_func == FUNC_WRITE);
    entry_nxt.cell_addr   = in_cell_addr;
    entry_nxt.cell_symbol = in_cell_symbol;
    entry_nxt.cell_value  = in_cell_value;
    entry_nxt.key_byte    = in_key_byte;
    entry_nxt.key_last    = in_key_last;
    entry_nxt.wr_in_table = ({9'd0, in_cell_addr} < TC);
    entry_nxt.byte_zero   = (in_key_byte == 8'd0);
    entry_nxt.byte_final  = (in_key_byte == 8'(FINAL_MARK));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ----- sv/pakl_queue.sv -----
// ----------------------------------------------------------------------------
// pakl_queue
// Short FIFO of classified beats between the front and back stages.
// ----------------------------------------------------------------------------
module pakl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pakl_pkg::entry_t push_entry,
  output logic             q_ready,
  output logic             q_valid,
  output pakl_pkg::entry_t q_head,
  input  logic             pop
);
  import pakl_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  entry_t         slot_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign q_ready = (count_r != CW'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/pakl_back.sv -----
// ----------------------------------------------------------------------------
// pakl_back
// Execution stage: owns the cell table, walks keys and drives the result.
// ----------------------------------------------------------------------------
module pakl_back #(
  parameter int TABLE_CELLS = 65536,
  parameter int FINAL_MARK  = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pakl_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  pakl_pkg::entry_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [31:0]      out_data_offset
);
  import pakl_pkg::*;

  localparam int AW     = $clog2(TABLE_CELLS);
  localparam int CELL_W = SYM_W + VALUE_W;
  localparam logic [32:0] TC = 33'(TABLE_CELLS);
  localparam logic [32:0] FM = 33'(FINAL_MARK);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_STEP = 3'b010,
    ST_FIN  = 3'b100
  } back_state_t;

  logic [CELL_W-1:0] cell_mem [0:TABLE_CELLS-1];

  back_state_t        state_r, state_nxt;
  logic               in_key_r, in_key_nxt;
  logic               walk_failed_r, walk_failed_nxt;
  logic [31:0]        walk_cell_r, walk_cell_nxt;
  logic [7:0]         cur_byte_r, cur_byte_nxt;
  logic               cur_last_r, cur_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [31:0]        out_offset_r, out_offset_nxt;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [CELL_W-1:0]  rd_q;
  logic               wr_en;
  logic [AW+15:0]     wr_wide;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         rd_sym;
  logic [31:0]        rd_val;

  logic [31:0]        base_cell;
  logic               base_fail;
  logic [32:0]        sum_b, sum_f, sum_v;
  logic               step_ok, fail_now, matched, can_emit;
  logic               emit, emit_found;
  logic [31:0]        emit_offset;

  assign wr_wide = {{AW{1'b0}}, q_head.cell_addr};
  assign wr_addr = wr_wide[AW-1:0];
  assign rd_sym  = rd_q[CELL_W-1:VALUE_W];
  assign rd_val  = rd_q[VALUE_W-1:0];

  assign base_cell = in_key_r ? walk_cell_r : {16'd0, cfg.start_cell};
  assign base_fail = in_key_r ? walk_failed_r
                              : (!cfg.table_ready || (cfg.start_cell == 16'd0));
  assign sum_b     = {1'b0, base_cell} + {25'd0, q_head.key_byte};
  assign sum_f     = {1'b0, base_cell} + FM;
  assign sum_v     = {1'b0, rd_val} + FM;
  assign step_ok   = !base_fail && !q_head.byte_zero && !q_head.byte_final && (sum_b < TC);
  assign fail_now  = base_fail || (!q_head.byte_zero && !step_ok);
  assign matched   = (rd_sym == cur_byte_r);
  assign can_emit  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    in_key_nxt      = in_key_r;
    walk_failed_nxt = walk_failed_r;
    walk_cell_nxt   = walk_cell_r;
    cur_byte_nxt    = cur_byte_r;
    cur_last_nxt    = cur_last_r;
    q_pop           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = sum_b[AW-1:0];
    wr_en           = 1'b0;
    emit            = 1'b0;
    emit_found      = 1'b0;
    emit_offset     = 32'd0;

    case (state_r)
      ST_RUN: begin
        if (q_valid) begin
          if (q_head.is_write) begin
            wr_en = q_head.wr_in_table;
            q_pop = 1'b1;
          end else if (step_ok) begin
            rd_en           = 1'b1;
            rd_addr         = sum_b[AW-1:0];
            q_pop           = 1'b1;
            in_key_nxt      = 1'b1;
            walk_cell_nxt   = base_cell;
            walk_failed_nxt = 1'b0;
            cur_byte_nxt    = q_head.key_byte;
            cur_last_nxt    = q_head.key_last;
            state_nxt       = ST_STEP;
          end else if (q_head.key_last) begin
            if (fail_now || (sum_f >= TC)) begin
              if (can_emit) begin
                emit            = 1'b1;
                q_pop           = 1'b1;
                in_key_nxt      = 1'b0;
                walk_failed_nxt = 1'b0;
              end
            end else begin
              rd_en           = 1'b1;
              rd_addr         = sum_f[AW-1:0];
              q_pop           = 1'b1;
              in_key_nxt      = 1'b1;
              walk_cell_nxt   = base_cell;
              walk_failed_nxt = 1'b0;
              state_nxt       = ST_FIN;
            end
          end else begin
            q_pop           = 1'b1;
            in_key_nxt      = 1'b1;
            walk_cell_nxt   = base_cell;
            walk_failed_nxt = fail_now;
          end
        end
      end
      ST_STEP: begin
        if (!cur_last_r) begin
          walk_cell_nxt   = matched ? rd_val : walk_cell_r;
          walk_failed_nxt = !matched;
          state_nxt       = ST_RUN;
        end else if (matched && (sum_v < TC)) begin
          rd_en         = 1'b1;
          rd_addr       = sum_v[AW-1:0];
          walk_cell_nxt = rd_val;
          state_nxt     = ST_FIN;
        end else if (can_emit) begin
          emit            = 1'b1;
          in_key_nxt      = 1'b0;
          walk_failed_nxt = 1'b0;
          state_nxt       = ST_RUN;
        end
      end
      ST_FIN: begin
        if (can_emit) begin
          emit            = 1'b1;
          emit_found      = (rd_sym == 8'(FINAL_MARK));
          emit_offset     = emit_found ? rd_val : 32'd0;
          in_key_nxt      = 1'b0;
          walk_failed_nxt = 1'b0;
          state_nxt       = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_found_nxt  = emit_found;
      out_offset_nxt = emit_offset;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RUN;
      in_key_r      <= 1'b0;
      walk_failed_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      in_key_r      <= in_key_nxt;
      walk_failed_r <= walk_failed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_cell_r  <= walk_cell_nxt;
    cur_byte_r   <= cur_byte_nxt;
    cur_last_r   <= cur_last_nxt;
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= {q_head.cell_symbol, q_head.cell_value};
    end
    if (rd_en) begin
      rd_q <= cell_mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_data_offset = out_offset_r;

endmodule

// ----- sv/packed_automaton_key_lookup.sv -----
// ----------------------------------------------------------------------------
// packed_automaton_key_lookup
// Double-array automaton walk over a cell table loaded by write beats.
// ----------------------------------------------------------------------------
// Result path: a key_last beat with no transition reads the final-marker cell
//   (state ST_FIN) before it reports; a beat on an already failed key reports
//   from ST_RUN; a transition on the last beat adds a table read before it.
// Throughput: write beats retire in ST_RUN; a key byte holds the back stage in a
//   read-compare loop on the single table port; front and queue absorb stalls.
// Reset: control state and config clear; the cell table is not cleared.
module packed_automaton_key_lookup #(
  parameter int TABLE_CELLS = 65536,
  parameter int FINAL_MARK  = 255
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pakl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pakl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic [15:0]                          in_cell_addr,
  input  logic [7:0]                           in_cell_symbol,
  input  logic [31:0]                          in_cell_value,
  input  logic [7:0]                           in_key_byte,
  input  logic                                 in_key_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic [31:0]                          out_data_offset
);
  import pakl_pkg::*;

  cfg_t   cfg_r;
  logic   push, q_ready, q_valid, q_pop;
  entry_t push_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.table_ready <= 1'b0;
      cfg_r.start_cell  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_READY: cfg_r.table_ready <= cfg_wdata[0];
        CFG_START_CELL:  cfg_r.start_cell  <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  pakl_front #(
    .TABLE_CELLS (TABLE_CELLS),
    .FINAL_MARK  (FINAL_MARK)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_cell_addr   (in_cell_addr),
    .in_cell_symbol (in_cell_symbol),
    .in_cell_value  (in_cell_value),
    .in_key_byte    (in_key_byte),
    .in_key_last    (in_key_last),
    .push           (push),
    .push_entry     (push_entry),
    .q_ready        (q_ready)
  );

  pakl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (q_pop)
  );

  pakl_back #(
    .TABLE_CELLS (TABLE_CELLS),
    .FINAL_MARK  (FINAL_MARK)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_data_offset (out_data_offset)
  );

endmodule

// ----- sv/pakl_checker.sv -----
// ----------------------------------------------------------------------------
// pakl_checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pakl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_data_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_found) && $stable(out_data_offset))
    else $error("result payload changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_data_offset == 32'd0)
    else $error("miss reported with nonzero offset");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind packed_automaton_key_lookup pakl_checker u_pakl_checker (.*);
